// ===== hw/rtl/m3i_pkg.sv =====
package m3i_pkg;

  localparam int unsigned ElementBits  = 32;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned Lanes        = 9;

  // cofactor i = e[CofA[i]] * e[CofB[i]] - e[CofC[i]] * e[CofD[i]]
  localparam int unsigned CofA [Lanes] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned CofB [Lanes] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned CofC [Lanes] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int unsigned CofD [Lanes] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  // determinant expands along row 0 with these cofactors
  localparam int unsigned DetCof [3] = '{0, 3, 6};

  function automatic int unsigned max_bits(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/m3i_div_step.sv =====
module m3i_div_step #(
  parameter int unsigned RemBits  = 132,
  parameter int unsigned DivBits  = 99,
  parameter int unsigned QuoBits  = 33,
  parameter int unsigned Step     = 0,
  parameter int unsigned SideBits = 19
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [m3i_pkg::Lanes-1:0][RemBits-1:0]       rem_i,
  input  logic [m3i_pkg::Lanes-1:0][QuoBits-1:0]       quo_i,
  input  logic [DivBits-1:0]                           div_i,
  input  logic [SideBits-1:0]                          side_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output logic [m3i_pkg::Lanes-1:0][RemBits-1:0]       rem_o,
  output logic [m3i_pkg::Lanes-1:0][QuoBits-1:0]       quo_o,
  output logic [DivBits-1:0]                           div_o,
  output logic [SideBits-1:0]                          side_o
);

  logic                                    valid_q;
  logic [RemBits-1:0]                      trial;
  logic [m3i_pkg::Lanes-1:0][RemBits-1:0]  rem_d, rem_q;
  logic [m3i_pkg::Lanes-1:0][QuoBits-1:0]  quo_d, quo_q;
  logic [DivBits-1:0]                      div_q;
  logic [SideBits-1:0]                     side_q;
  logic                                    ge;

  assign ready_o = !valid_q || ready_i;

  // one restoring step per lane: try the divisor at this quotient bit
  always_comb begin
    trial = RemBits'(div_i) << Step;
    ge    = 1'b0;
    for (int l = 0; l < int'(m3i_pkg::Lanes); l++) begin
      ge          = rem_i[l] >= trial;
      rem_d[l]    = ge ? (rem_i[l] - trial) : rem_i[l];
      quo_d[l]    = quo_i[l];
      quo_d[l][Step] = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, exact fixed point.
// Input channel: in_valid_i/in_ready_o with nine signed entries in row order,
// ElementBits wide with FractionBits fraction bits. Output channel:
// out_valid_o/out_ready_i with the nine inverse entries, singular_o and
// saturated_o. Each entry is cofactor * 2^(2*FractionBits) / determinant,
// truncated toward zero and clipped to range (saturated_o set on a clip).
// A zero determinant gives zero entries with singular_o set.
// Throughput: one item per cycle unless out_ready_i stalls. Seven
// arithmetic stages (products, cofactors, split determinant products,
// their sums, magnitudes, range check) feed a divider of ElementBits + 1
// restoring stages, one quotient bit per stage for all nine entries, then
// the clip and output register.
// Every stage holds its own valid bit; a stall of out_ready_i fills the
// bubbles first and in_ready_o only drops once every stage is full.
// Reset clears all valid bits; no item is in flight after reset.
module matrix3x3_inverse #(
  parameter int unsigned ElementBits  = m3i_pkg::ElementBits,
  parameter int unsigned FractionBits = m3i_pkg::FractionBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ElementBits-1:0] in_r0c0_i,
  input  logic [ElementBits-1:0] in_r0c1_i,
  input  logic [ElementBits-1:0] in_r0c2_i,
  input  logic [ElementBits-1:0] in_r1c0_i,
  input  logic [ElementBits-1:0] in_r1c1_i,
  input  logic [ElementBits-1:0] in_r1c2_i,
  input  logic [ElementBits-1:0] in_r2c0_i,
  input  logic [ElementBits-1:0] in_r2c1_i,
  input  logic [ElementBits-1:0] in_r2c2_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ElementBits-1:0] out_r0c0_o,
  output logic [ElementBits-1:0] out_r0c1_o,
  output logic [ElementBits-1:0] out_r0c2_o,
  output logic [ElementBits-1:0] out_r1c0_o,
  output logic [ElementBits-1:0] out_r1c1_o,
  output logic [ElementBits-1:0] out_r1c2_o,
  output logic [ElementBits-1:0] out_r2c0_o,
  output logic [ElementBits-1:0] out_r2c1_o,
  output logic [ElementBits-1:0] out_r2c2_o,
  output logic                   singular_o,
  output logic                   saturated_o
);

  localparam int unsigned Lanes       = m3i_pkg::Lanes;
  localparam int unsigned ProdBits    = 2 * ElementBits;
  localparam int unsigned CofBits     = ProdBits + 1;
  localparam int unsigned PartBits    = 2 * ElementBits + 1;
  localparam int unsigned TermBits    = 3 * ElementBits + 1;
  localparam int unsigned DetBits     = 3 * ElementBits + 3;
  localparam int unsigned NumBits     = CofBits + 2 * FractionBits;
  localparam int unsigned QuoBits     = ElementBits + 1;
  localparam int unsigned RemBits     = m3i_pkg::max_bits(NumBits, DetBits + QuoBits);
  localparam int unsigned SideBits    = 2 * Lanes + 1;
  localparam int unsigned FrontStages = 7;
  localparam logic [QuoBits-1:0] Limit = QuoBits'(1) << (ElementBits - 1);

  logic signed [ElementBits-1:0] in_e [9];

  assign in_e[0] = in_r0c0_i;
  assign in_e[1] = in_r0c1_i;
  assign in_e[2] = in_r0c2_i;
  assign in_e[3] = in_r1c0_i;
  assign in_e[4] = in_r1c1_i;
  assign in_e[5] = in_r1c2_i;
  assign in_e[6] = in_r2c0_i;
  assign in_e[7] = in_r2c1_i;
  assign in_e[8] = in_r2c2_i;

  // front pipeline handshake
  logic [FrontStages-1:0] fv_q;
  logic [FrontStages-1:0] frdy;
  logic                   out_v_q;
  logic                   out_rdy;
  logic [QuoBits:0]       dv;
  logic [QuoBits:0]       drdy;

  always_comb begin
    frdy[FrontStages-1] = !fv_q[FrontStages-1] || drdy[0];
    for (int s = FrontStages - 2; s >= 0; s--) begin
      frdy[s] = !fv_q[s] || frdy[s+1];
    end
  end

  assign in_ready_o = frdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (frdy[0]) begin
        fv_q[0] <= in_valid_i;
      end
      for (int s = 1; s < int'(FrontStages); s++) begin
        if (frdy[s]) begin
          fv_q[s] <= fv_q[s-1];
        end
      end
    end
  end

  // stage 1: the eighteen 2x2 products
  logic signed [ProdBits-1:0]    s1_p_d [2*Lanes];
  logic signed [ProdBits-1:0]    s1_p_q [2*Lanes];
  logic signed [ElementBits-1:0] s1_e_q [3];

  always_comb begin
    for (int i = 0; i < int'(Lanes); i++) begin
      s1_p_d[2*i]   = in_e[m3i_pkg::CofA[i]] * in_e[m3i_pkg::CofB[i]];
      s1_p_d[2*i+1] = in_e[m3i_pkg::CofC[i]] * in_e[m3i_pkg::CofD[i]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frdy[0]) begin
      s1_p_q <= s1_p_d;
      for (int k = 0; k < 3; k++) begin
        s1_e_q[k] <= in_e[k];
      end
    end
  end

  // stage 2: cofactors
  logic signed [CofBits-1:0]     s2_c_d [Lanes];
  logic signed [CofBits-1:0]     s2_c_q [Lanes];
  logic signed [ElementBits-1:0] s2_e_q [3];

  always_comb begin
    for (int i = 0; i < int'(Lanes); i++) begin
      s2_c_d[i] = CofBits'(s1_p_q[2*i]) - CofBits'(s1_p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frdy[1]) begin
      s2_c_q <= s2_c_d;
      s2_e_q <= s1_e_q;
    end
  end

  // stage 3: row 0 entry times cofactor, cofactor split in a low and a high half
  logic signed [PartBits-1:0] s3_lo_d [3];
  logic signed [PartBits-1:0] s3_hi_d [3];
  logic signed [PartBits-1:0] s3_lo_q [3];
  logic signed [PartBits-1:0] s3_hi_q [3];
  logic signed [CofBits-1:0]  s3_c_q  [Lanes];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_lo_d[k] = s2_e_q[k] *
                   $signed({1'b0, s2_c_q[m3i_pkg::DetCof[k]][ElementBits-1:0]});
      s3_hi_d[k] = s2_e_q[k] *
                   $signed(s2_c_q[m3i_pkg::DetCof[k]][CofBits-1:ElementBits]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frdy[2]) begin
      s3_lo_q <= s3_lo_d;
      s3_hi_q <= s3_hi_d;
      s3_c_q  <= s2_c_q;
    end
  end

  // stage 4: recombine the halves
  logic signed [TermBits-1:0] s4_t_d [3];
  logic signed [TermBits-1:0] s4_t_q [3];
  logic signed [CofBits-1:0]  s4_c_q [Lanes];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_t_d[k] = (TermBits'(s3_hi_q[k]) <<< ElementBits) + TermBits'(s3_lo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frdy[3]) begin
      s4_t_q <= s4_t_d;
      s4_c_q <= s3_c_q;
    end
  end

  // stage 5: determinant
  logic signed [DetBits-1:0] s5_det_d;
  logic signed [DetBits-1:0] s5_det_q;
  logic signed [CofBits-1:0] s5_c_q [Lanes];

  assign s5_det_d = DetBits'(s4_t_q[0]) + DetBits'(s4_t_q[1]) + DetBits'(s4_t_q[2]);

  always_ff @(posedge clk_i) begin
    if (frdy[4]) begin
      s5_det_q <= s5_det_d;
      s5_c_q   <= s4_c_q;
    end
  end

  // stage 6: magnitudes and result signs
  logic [CofBits-1:0] s6_magc_d [Lanes];
  logic [CofBits-1:0] s6_magc_q [Lanes];
  logic [DetBits-1:0] s6_magd_d, s6_magd_q;
  logic [Lanes-1:0]   s6_neg_d, s6_neg_q;
  logic               s6_sing_d, s6_sing_q;

  always_comb begin
    for (int i = 0; i < int'(Lanes); i++) begin
      s6_magc_d[i] = s5_c_q[i][CofBits-1] ? $unsigned(-s5_c_q[i]) : $unsigned(s5_c_q[i]);
      s6_neg_d[i]  = s5_c_q[i][CofBits-1] ^ s5_det_q[DetBits-1];
    end
    s6_magd_d = s5_det_q[DetBits-1] ? $unsigned(-s5_det_q) : $unsigned(s5_det_q);
    s6_sing_d = (s5_det_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (frdy[5]) begin
      s6_magc_q <= s6_magc_d;
      s6_magd_q <= s6_magd_d;
      s6_neg_q  <= s6_neg_d;
      s6_sing_q <= s6_sing_d;
    end
  end

  // stage 7: scale numerators, flag quotients too large for the divider
  logic [Lanes-1:0][RemBits-1:0] s7_rem_d, s7_rem_q;
  logic [Lanes-1:0]              s7_big_d, s7_big_q;
  logic [Lanes-1:0]              s7_neg_q;
  logic                          s7_sing_q;
  logic [DetBits-1:0]            s7_magd_q;
  logic [RemBits-1:0]            s7_bound;

  always_comb begin
    s7_bound = RemBits'(s6_magd_q) << QuoBits;
    for (int i = 0; i < int'(Lanes); i++) begin
      s7_rem_d[i] = RemBits'(s6_magc_q[i]) << (2 * FractionBits);
      s7_big_d[i] = s7_rem_d[i] >= s7_bound;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frdy[6]) begin
      s7_rem_q  <= s7_rem_d;
      s7_big_q  <= s7_big_d;
      s7_neg_q  <= s6_neg_q;
      s7_sing_q <= s6_sing_q;
      s7_magd_q <= s6_magd_q;
    end
  end

  // divider: one quotient bit per stage, most significant first
  logic [Lanes-1:0][RemBits-1:0] dr [QuoBits+1];
  logic [Lanes-1:0][QuoBits-1:0] dq [QuoBits+1];
  logic [DetBits-1:0]            dd [QuoBits+1];
  logic [SideBits-1:0]           ds [QuoBits+1];

  assign dv[0] = fv_q[FrontStages-1];
  assign dr[0] = s7_rem_q;
  assign dq[0] = '0;
  assign dd[0] = s7_magd_q;
  assign ds[0] = {s7_sing_q, s7_neg_q, s7_big_q};
  assign drdy[QuoBits] = out_rdy;

  for (genvar s = 0; s < int'(QuoBits); s++) begin : g_div
    m3i_div_step #(
      .RemBits (RemBits),
      .DivBits (DetBits),
      .QuoBits (QuoBits),
      .Step    (QuoBits - 1 - s),
      .SideBits(SideBits)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[s]),
      .ready_o(drdy[s]),
      .rem_i  (dr[s]),
      .quo_i  (dq[s]),
      .div_i  (dd[s]),
      .side_i (ds[s]),
      .valid_o(dv[s+1]),
      .ready_i(drdy[s+1]),
      .rem_o  (dr[s+1]),
      .quo_o  (dq[s+1]),
      .div_o  (dd[s+1]),
      .side_o (ds[s+1])
    );
  end

  // clip, sign and output register
  logic [Lanes-1:0]       f_big, f_neg;
  logic                   f_sing;
  logic [QuoBits-1:0]     f_q, f_mag, f_negq;
  logic                   f_over;
  logic [ElementBits-1:0] out_e_d [Lanes];
  logic [ElementBits-1:0] out_e_q [Lanes];
  logic                   out_sat_d, out_sat_q, out_sing_q;

  assign {f_sing, f_neg, f_big} = ds[QuoBits];

  always_comb begin
    out_sat_d = 1'b0;
    f_q       = '0;
    f_mag     = '0;
    f_negq    = '0;
    f_over    = 1'b0;
    for (int i = 0; i < int'(Lanes); i++) begin
      f_q = dq[QuoBits][i];
      if (f_neg[i]) begin
        f_over = f_big[i] || (f_q > Limit);
        f_mag  = f_over ? Limit : f_q;
      end else begin
        f_over = f_big[i] || (f_q > (Limit - 1'b1));
        f_mag  = f_over ? (Limit - 1'b1) : f_q;
      end
      f_negq = '0 - f_mag;
      if (f_sing) begin
        out_e_d[i] = '0;
      end else begin
        out_e_d[i] = f_neg[i] ? f_negq[ElementBits-1:0] : f_mag[ElementBits-1:0];
        out_sat_d  = out_sat_d | f_over;
      end
    end
  end

  assign out_rdy = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_e_q    <= out_e_d;
      out_sat_q  <= out_sat_d;
      out_sing_q <= f_sing;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_r0c0_o  = out_e_q[0];
  assign out_r0c1_o  = out_e_q[1];
  assign out_r0c2_o  = out_e_q[2];
  assign out_r1c0_o  = out_e_q[3];
  assign out_r1c1_o  = out_e_q[4];
  assign out_r1c2_o  = out_e_q[5];
  assign out_r2c0_o  = out_e_q[6];
  assign out_r2c1_o  = out_e_q[7];
  assign out_r2c2_o  = out_e_q[8];
  assign singular_o  = out_sing_q;
  assign saturated_o = out_sat_q;

endmodule

// ===== hw/rtl/m3i_checker.sv =====
module m3i_checker #(
  parameter int unsigned ElementBits = m3i_pkg::ElementBits
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ElementBits-1:0] out_r0c0_o,
  input logic [ElementBits-1:0] out_r0c1_o,
  input logic [ElementBits-1:0] out_r0c2_o,
  input logic [ElementBits-1:0] out_r1c0_o,
  input logic [ElementBits-1:0] out_r1c1_o,
  input logic [ElementBits-1:0] out_r1c2_o,
  input logic [ElementBits-1:0] out_r2c0_o,
  input logic [ElementBits-1:0] out_r2c1_o,
  input logic [ElementBits-1:0] out_r2c2_o,
  input logic                   singular_o,
  input logic                   saturated_o
);

  localparam logic [ElementBits-1:0] MaxVal = {1'b0, {(ElementBits-1){1'b1}}};
  localparam logic [ElementBits-1:0] MinVal = {1'b1, {(ElementBits-1){1'b0}}};

  function automatic logic at_edge(logic [ElementBits-1:0] v);
    return (v == MaxVal) || (v == MinVal);
  endfunction

  logic any_edge, all_zero;

  assign any_edge = at_edge(out_r0c0_o) || at_edge(out_r0c1_o) || at_edge(out_r0c2_o) ||
                    at_edge(out_r1c0_o) || at_edge(out_r1c1_o) || at_edge(out_r1c2_o) ||
                    at_edge(out_r2c0_o) || at_edge(out_r2c1_o) || at_edge(out_r2c2_o);
  assign all_zero = (out_r0c0_o == '0) && (out_r0c1_o == '0) && (out_r0c2_o == '0) &&
                    (out_r1c0_o == '0) && (out_r1c1_o == '0) && (out_r1c2_o == '0) &&
                    (out_r2c0_o == '0) && (out_r2c1_o == '0) && (out_r2c2_o == '0);

  // a stalled result item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_r0c0_o) &&
    $stable(out_r1c1_o) && $stable(out_r2c2_o) && $stable(singular_o) &&
    $stable(saturated_o))
    else $error("result item changed while stalled");

  // zero determinant gives an all-zero, unclipped result
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> all_zero && !saturated_o)
    else $error("singular result not cleared");

  // a clip leaves at least one entry at a range limit
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> any_edge)
    else $error("saturated flag without a clipped entry");

  // input backs up only when the whole pipeline is full and stalled
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

endmodule

bind matrix3x3_inverse m3i_checker #(.ElementBits(ElementBits)) u_m3i_checker (.*);

// ===== dv/tb.sv =====
module tb;

  typedef logic [8:0][m3i_pkg::ElementBits-1:0] matrix_t;

  typedef struct packed {
    matrix_t ent;
    logic    sing;
    logic    sat;
  } inverse_t;

  localparam int unsigned CycleLimit = 400000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  matrix_t mat_in = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  matrix_t mat_out;
  logic    singular_o;
  logic    saturated_o;

  inverse_t    expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_singular = 0;
  int unsigned n_saturated = 0;
  bit          idle_en = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  matrix3x3_inverse uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_r0c0_i  (mat_in[0]),
    .in_r0c1_i  (mat_in[1]),
    .in_r0c2_i  (mat_in[2]),
    .in_r1c0_i  (mat_in[3]),
    .in_r1c1_i  (mat_in[4]),
    .in_r1c2_i  (mat_in[5]),
    .in_r2c0_i  (mat_in[6]),
    .in_r2c1_i  (mat_in[7]),
    .in_r2c2_i  (mat_in[8]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_r0c0_o (mat_out[0]),
    .out_r0c1_o (mat_out[1]),
    .out_r0c2_o (mat_out[2]),
    .out_r1c0_o (mat_out[3]),
    .out_r1c1_o (mat_out[4]),
    .out_r1c2_o (mat_out[5]),
    .out_r2c0_o (mat_out[6]),
    .out_r2c1_o (mat_out[7]),
    .out_r2c2_o (mat_out[8]),
    .singular_o (singular_o),
    .saturated_o(saturated_o)
  );

  // exact adjugate over det, truncated toward zero, clipped
  function automatic inverse_t predict_inverse(input matrix_t m);
    logic signed [127:0] e[9];
    logic signed [127:0] cof[9];
    logic signed [127:0] det;
    logic [127:0]        num;
    logic [127:0]        den;
    logic [127:0]        quo;
    logic                neg;
    inverse_t            r;
    r = '0;
    for (int i = 0; i < 9; i++) e[i] = {{96{m[i][31]}}, m[i]};
    for (int i = 0; i < 9; i++) begin
      cof[i] = e[m3i_pkg::CofA[i]] * e[m3i_pkg::CofB[i]] -
               e[m3i_pkg::CofC[i]] * e[m3i_pkg::CofD[i]];
    end
    det = e[0] * cof[m3i_pkg::DetCof[0]] + e[1] * cof[m3i_pkg::DetCof[1]] +
          e[2] * cof[m3i_pkg::DetCof[2]];
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    den = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      num = (cof[i] < 0) ? -cof[i] : cof[i];
      num = num << (2 * m3i_pkg::FractionBits);
      quo = num / den;
      neg = (cof[i] < 0) ^ (det < 0);
      if (neg) begin
        if (quo > 128'h8000_0000) begin
          quo = 128'h8000_0000;
          r.sat = 1'b1;
        end
        r.ent[i] = -quo[31:0];
      end else begin
        if (quo > 128'h7fff_ffff) begin
          quo = 128'h7fff_ffff;
          r.sat = 1'b1;
        end
        r.ent[i] = quo[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, exp, n_checked);
    errors++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_matrix(input matrix_t m);
    inverse_t p;
    in_valid_i = 1'b1;
    mat_in     = m;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_inverse(m);
    expected_q.push_back(p);
    n_sent++;
    if (p.sing) n_singular++;
    if (p.sat) n_saturated++;
    @(negedge clk_i);
    if (idle_en && $urandom_range(99) < 38) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = !idle_en || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    inverse_t exp;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result %0d", n_checked);
        errors++;
      end else begin
        exp = expected_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (mat_out[i] !== exp.ent[i]) report_mismatch($sformatf("entry %0d", i),
                                                         mat_out[i], exp.ent[i]);
        end
        if (singular_o !== exp.sing) report_mismatch("singular", 32'(singular_o),
                                                     32'(exp.sing));
        if (saturated_o !== exp.sat) report_mismatch("saturated", 32'(saturated_o),
                                                     32'(exp.sat));
      end
      n_checked++;
    end
  end

  function automatic matrix_t diag(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c);
    matrix_t m;
    m    = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    matrix_t m;
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix('0);
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag(32'hffff_ffff, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag(32'hffff_0000, 32'hffff_0000, 32'h0001_0000));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000));
    send_matrix(diag(32'h0002_0000, 32'h0004_0000, 32'h0008_0000));
    // thirds and a seventh, truncated toward zero on both signs
    send_matrix(diag(32'h0003_0000, 32'hfffd_0000, 32'h0007_0000));
    send_matrix(diag(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    m = '0;
    m[1] = 32'h0001_0000; m[5] = 32'h0001_0000; m[6] = 32'h0001_0000;
    send_matrix(m);
    m = {9{32'h0001_0000}};
    m[0] = 32'h0002_0000; m[4] = 32'hfffe_0000;
    send_matrix(m);
    m = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    send_matrix(m);
    m = {32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004, 32'h0000_0005,
         32'h0000_0006, 32'h0000_0007, 32'h0000_0008, 32'h0000_000a};
    send_matrix(m);
  endtask

  function automatic matrix_t random_matrix();
    matrix_t m;
    int unsigned kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 30) m[i] = $urandom();
      else m[i] = $urandom_range(32'h0008_0000) - 32'h0004_0000;
    end
    if (kind >= 90) begin
      // repeated row forces a zero determinant
      m[8:6] = m[2:0];
    end else if (kind >= 80) begin
      m[0] = $urandom_range(3); m[4] = $urandom_range(3); m[8] = $urandom_range(3);
    end
    return m;
  endfunction

  task automatic test_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      idle_en = !(k >= 400 && k < 700);
      if (k == 900) begin
        in_valid_i = 1'b0;
        wait_drained();
      end
      send_matrix(random_matrix());
    end
    idle_en    = 1'b1;
    in_valid_i = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1400);
    in_valid_i = 1'b0;
    wait_drained();
    repeat (60) @(negedge clk_i);
    $display("sent %0d matrices, checked %0d inverses", n_sent, n_checked);
    $display("of which %0d singular and %0d clipped", n_singular, n_saturated);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
